FILE: hdl/aiff_hp_pkg.sv
// ----------------------------------------------------------------------------
// AIFF header parser package
// Shared constants, codes and the result bundle passed from the parser to the
// output stage.
// ----------------------------------------------------------------------------
package aiff_hp_pkg;

  localparam int OFFSET_BITS_DEF = 32;

  localparam logic [31:0] TAG_FORM = 32'h464F524D;
  localparam logic [31:0] TAG_AIFF = 32'h41494646;
  localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
  localparam logic [31:0] TAG_SSND = 32'h53534E44;

  localparam logic [14:0] EXP_MAX  = 15'h7FFF;
  localparam logic [14:0] EXP_BIAS = 15'd16383;
  // Exponent at which the shift in aiff_hp_rate is zero (bias + 63 + 32).
  localparam logic [14:0] EXP_SAT  = 15'd16478;

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_CHID = 3'd1;
  localparam logic [2:0] PH_PEND = 3'd2;
  localparam logic [2:0] PH_BODY = 3'd3;
  localparam logic [2:0] PH_HALT = 3'd4;

  localparam logic [1:0] CK_OTHER = 2'd0;
  localparam logic [1:0] CK_COMM  = 2'd1;
  localparam logic [1:0] CK_SSND  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FORM  = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE = 3'd2;
  localparam logic [2:0] ST_NO_AIFF  = 3'd3;
  localparam logic [2:0] ST_BAD_BPS  = 3'd4;

  localparam logic KIND_PCM = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  typedef struct packed {
    logic        pcm_v;
    logic        sum_v;
    logic [7:0]  pcm_byte;
    logic        pcm_run_end;
    logic [15:0] channels;
    logic [1:0]  sample_bytes;
    logic [15:0] sign_exp;
    logic [63:0] mantissa;
    logic [31:0] pcm_begin;
    logic [31:0] pcm_end;
    logic [2:0]  status;
  } parse_res_t;

endpackage

FILE: hdl/aiff_hp_rate.sv
// ----------------------------------------------------------------------------
// AIFF sample rate conversion
// Truncates an 80-bit extended value to an unsigned 32-bit integer with one
// right shift of the mantissa, saturating on overflow, infinity and NaN.
// ----------------------------------------------------------------------------
module aiff_hp_rate (
  input  logic [15:0] sign_exp,
  input  logic [63:0] mantissa,
  output logic [31:0] rate
);

  logic [14:0] exp_w;
  logic [14:0] amt_w;
  logic [95:0] shifted;

  assign exp_w   = sign_exp[14:0];
  assign amt_w   = aiff_hp_pkg::EXP_SAT - exp_w;
  // The mantissa sits above 32 fraction bits; shifting right by (32 - k)
  // gives the integer part in the low word and any overflow above it.
  assign shifted = {mantissa, 32'd0} >> amt_w[6:0];

  always_comb begin
    if (exp_w == 15'd0 && mantissa == 64'd0) begin
      rate = 32'd0;
    end else if (sign_exp[15]) begin
      rate = 32'd0;
    end else if (exp_w == aiff_hp_pkg::EXP_MAX) begin
      rate = 32'hFFFF_FFFF;
    end else if (exp_w < aiff_hp_pkg::EXP_BIAS) begin
      rate = 32'd0;
    end else if (exp_w >= aiff_hp_pkg::EXP_SAT) begin
      rate = 32'hFFFF_FFFF;
    end else if (shifted[95:32] != 64'd0) begin
      rate = 32'hFFFF_FFFF;
    end else begin
      rate = shifted[31:0];
    end
  end

endmodule

FILE: hdl/aiff_hp_parse.sv
// ----------------------------------------------------------------------------
// AIFF container parser
// Holds the parse state, updates it once per accepted byte and forms the
// pass-through and end-of-file results for that byte.
// ----------------------------------------------------------------------------
module aiff_hp_parse #(
  parameter int OFFSET_BITS = aiff_hp_pkg::OFFSET_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output aiff_hp_pkg::parse_res_t res
);

  localparam logic [OFFSET_BITS-1:0] OFFMAX   = {OFFSET_BITS{1'b1}};
  localparam logic [32:0]            OFFMAX_W = 33'(OFFMAX);

  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [31:0]            fse_r, fse_nxt;
  logic [63:0]            hs_r, hs_nxt;
  logic [2:0]             phase_r, phase_nxt;
  logic [1:0]             ckind_r, ckind_nxt;
  logic [OFFSET_BITS-1:0] cds_r, cds_nxt;
  logic [OFFSET_BITS-1:0] ceo_r, ceo_nxt;
  logic [15:0]            chan_r, chan_nxt;
  logic [1:0]             bps_r, bps_nxt;
  logic [15:0]            sexp_r, sexp_nxt;
  logic [63:0]            mant_r, mant_nxt;
  logic [OFFSET_BITS-1:0] pst_r, pst_nxt;
  logic [OFFSET_BITS-1:0] pend_r, pend_nxt;
  logic [2:0]             err_r, err_nxt;

  logic [OFFSET_BITS-1:0] rel;
  logic [15:0]            low16;
  logic [2:0]             lane;
  logic [32:0]            end_sum;
  logic [32:0]            start_sum;
  logic [OFFSET_BITS-1:0] end_sat;
  logic [OFFSET_BITS-1:0] start_sat;
  logic                   body_end;
  logic                   ssnd_now;
  logic                   pcm_hit;
  logic [OFFSET_BITS-1:0] total;
  logic [OFFSET_BITS-1:0] end_clip;
  logic [2:0]             status;
  logic                   ok;

  assign end_sum   = {1'b0, 32'(off_r)} + {1'b0, hs_r[31:0]};
  assign start_sum = {1'b0, 32'(off_r)} + 33'd8;
  assign end_sat   = (end_sum > OFFMAX_W) ? OFFMAX : end_sum[OFFSET_BITS-1:0];
  assign start_sat = (start_sum > OFFMAX_W) ? OFFMAX : start_sum[OFFSET_BITS-1:0];

  always_comb begin
    off_nxt   = off_r;
    fse_nxt   = fse_r;
    hs_nxt    = hs_r;
    phase_nxt = phase_r;
    ckind_nxt = ckind_r;
    cds_nxt   = cds_r;
    ceo_nxt   = ceo_r;
    chan_nxt  = chan_r;
    bps_nxt   = bps_r;
    sexp_nxt  = sexp_r;
    mant_nxt  = mant_r;
    pst_nxt   = pst_r;
    pend_nxt  = pend_r;
    err_nxt   = err_r;
    ssnd_now  = 1'b0;
    body_end  = 1'b0;
    rel       = '0;
    low16     = '0;
    lane      = '0;

    if (phase_r == aiff_hp_pkg::PH_HDR) begin
      hs_nxt = {hs_r[55:0], data_byte};
      if (off_r == OFFSET_BITS'(3) && hs_nxt[31:0] != aiff_hp_pkg::TAG_FORM) begin
        err_nxt   = aiff_hp_pkg::ST_NO_FORM;
        phase_nxt = aiff_hp_pkg::PH_HALT;
      end else if (off_r == OFFSET_BITS'(7)) begin
        fse_nxt = hs_nxt[31:0] + 32'd8;
      end else if (off_r == OFFSET_BITS'(11)) begin
        if (hs_nxt[31:0] != aiff_hp_pkg::TAG_AIFF) begin
          err_nxt   = aiff_hp_pkg::ST_NO_AIFF;
          phase_nxt = aiff_hp_pkg::PH_HALT;
        end else begin
          phase_nxt = aiff_hp_pkg::PH_CHID;
          ceo_nxt   = OFFSET_BITS'(12);
          hs_nxt    = '0;
        end
      end
    end else if (phase_r != aiff_hp_pkg::PH_HALT) begin
      if (phase_r == aiff_hp_pkg::PH_PEND) begin
        // The byte after a complete chunk header commits that header.
        cds_nxt = off_r;
        ceo_nxt = end_sat;
        if (hs_r[63:32] == aiff_hp_pkg::TAG_COMM) begin
          ckind_nxt = aiff_hp_pkg::CK_COMM;
        end else if (hs_r[63:32] == aiff_hp_pkg::TAG_SSND) begin
          ckind_nxt = aiff_hp_pkg::CK_SSND;
          pst_nxt   = start_sat;
          pend_nxt  = end_sat;
          ssnd_now  = 1'b1;
        end else begin
          ckind_nxt = aiff_hp_pkg::CK_OTHER;
        end
        hs_nxt    = '0;
        phase_nxt = aiff_hp_pkg::PH_BODY;
        // A new chunk ends at once only if it is empty or the offset is pinned.
        body_end  = (hs_r[31:0] == 32'd0) || (off_r == OFFMAX);
      end else begin
        body_end = (phase_r == aiff_hp_pkg::PH_BODY) && (off_r >= ceo_r);
      end

      if (body_end) begin
        phase_nxt = aiff_hp_pkg::PH_CHID;
        ceo_nxt   = off_r;
        hs_nxt    = '0;
      end

      if (phase_nxt == aiff_hp_pkg::PH_BODY) begin
        if (ckind_nxt == aiff_hp_pkg::CK_COMM) begin
          rel    = off_r - cds_nxt;
          low16  = {hs_nxt[7:0], data_byte};
          hs_nxt = {hs_nxt[55:0], data_byte};
          lane   = 3'(OFFSET_BITS'(17) - rel);
          if (rel == OFFSET_BITS'(1)) begin
            chan_nxt = low16;
          end else if (rel == OFFSET_BITS'(7)) begin
            if (low16 == 16'd0 || low16 > 16'd16) begin
              err_nxt   = aiff_hp_pkg::ST_BAD_BPS;
              phase_nxt = aiff_hp_pkg::PH_HALT;
            end else begin
              bps_nxt = (low16 > 16'd8) ? 2'd2 : 2'd1;
            end
          end else if (rel == OFFSET_BITS'(9)) begin
            sexp_nxt = low16;
            mant_nxt = '0;
          end else if (rel >= OFFSET_BITS'(10) && rel <= OFFSET_BITS'(17)) begin
            mant_nxt = mant_r | ({56'd0, data_byte} << {lane, 3'b000});
          end
        end
      end else begin
        hs_nxt = {hs_nxt[55:0], data_byte};
        if ((off_r - ceo_nxt) == OFFSET_BITS'(7)) begin
          phase_nxt = aiff_hp_pkg::PH_PEND;
        end
      end
    end

    off_nxt = (off_r == OFFMAX) ? off_r : off_r + OFFSET_BITS'(1);
  end

  // A range set up by this very byte never covers it, so the old range is used.
  assign pcm_hit = (phase_nxt != aiff_hp_pkg::PH_HALT) && !ssnd_now &&
                   (off_r >= pst_r) && (off_r < pend_r);

  assign total    = off_nxt;
  assign end_clip = (pend_nxt < total) ? pend_nxt : total;

  always_comb begin
    if (err_nxt == aiff_hp_pkg::ST_NO_FORM || total < OFFSET_BITS'(4)) begin
      status = aiff_hp_pkg::ST_NO_FORM;
    end else if (total < OFFSET_BITS'(8) || fse_nxt != 32'(total)) begin
      status = aiff_hp_pkg::ST_BAD_SIZE;
    end else if (err_nxt == aiff_hp_pkg::ST_NO_AIFF || total < OFFSET_BITS'(12)) begin
      status = aiff_hp_pkg::ST_NO_AIFF;
    end else if (err_nxt == aiff_hp_pkg::ST_BAD_BPS) begin
      status = aiff_hp_pkg::ST_BAD_BPS;
    end else begin
      status = aiff_hp_pkg::ST_OK;
    end
  end

  assign ok = (status == aiff_hp_pkg::ST_OK);

  always_comb begin
    res.pcm_v        = pcm_hit;
    res.sum_v        = last_byte;
    res.pcm_byte     = data_byte;
    res.pcm_run_end  = !last_byte;
    res.channels     = ok ? chan_nxt : 16'd0;
    res.sample_bytes = ok ? bps_nxt : 2'd0;
    res.sign_exp     = ok ? sexp_nxt : 16'd0;
    res.mantissa     = ok ? mant_nxt : 64'd0;
    res.pcm_begin    = ok ? 32'(pst_nxt) : 32'd0;
    res.pcm_end      = ok ? 32'(end_clip) : 32'd0;
    res.status       = status;
  end

  // The final byte of a file returns the parser to its reset state.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      off_r   <= '0;
      fse_r   <= '0;
      hs_r    <= '0;
      phase_r <= aiff_hp_pkg::PH_HDR;
      ckind_r <= aiff_hp_pkg::CK_OTHER;
      cds_r   <= '0;
      ceo_r   <= '0;
      chan_r  <= '0;
      bps_r   <= '0;
      sexp_r  <= '0;
      mant_r  <= '0;
      pst_r   <= '0;
      pend_r  <= '0;
      err_r   <= aiff_hp_pkg::ST_OK;
    end else if (accept) begin
      off_r   <= off_nxt;
      fse_r   <= fse_nxt;
      hs_r    <= hs_nxt;
      phase_r <= phase_nxt;
      ckind_r <= ckind_nxt;
      cds_r   <= cds_nxt;
      ceo_r   <= ceo_nxt;
      chan_r  <= chan_nxt;
      bps_r   <= bps_nxt;
      sexp_r  <= sexp_nxt;
      mant_r  <= mant_nxt;
      pst_r   <= pst_nxt;
      pend_r  <= pend_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

FILE: hdl/aiff_header_parser.sv
// ----------------------------------------------------------------------------
// AIFF header parser: PCM pass-through and summary, taking one file byte per
// cycle while the output is not stalled. A result is held in a staging register
// and then in the output registers; a summary that follows a PCM result of the
// same byte goes out after it. The final byte of a file that also passes PCM
// holds the input until its PCM result has left the stage. Synchronous reset
// clears the parse state and the valid flags.
// ----------------------------------------------------------------------------
module aiff_header_parser #(
  parameter int OFFSET_BITS = aiff_hp_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_pcm_byte,
  output logic [15:0] out_channels,
  output logic [1:0]  out_sample_bytes,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_pcm_begin,
  output logic [31:0] out_pcm_end,
  output logic [2:0]  out_status,
  output logic        out_run_end
);

  aiff_hp_pkg::parse_res_t res;
  aiff_hp_pkg::parse_res_t stg_r;
  logic                    stg_pcm_v_r;
  logic                    stg_sum_v_r;
  logic                    in_fire;
  logic                    out_load;
  logic                    emit;
  logic [31:0]             rate;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_pcm_byte_r;
  logic [15:0] out_channels_r;
  logic [1:0]  out_sample_bytes_r;
  logic [31:0] out_sample_rate_r;
  logic [31:0] out_pcm_begin_r;
  logic [31:0] out_pcm_end_r;
  logic [2:0]  out_status_r;
  logic        out_run_end_r;

  aiff_hp_parse #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_fire),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .res       (res)
  );

  aiff_hp_rate u_rate (
    .sign_exp (stg_r.sign_exp),
    .mantissa (stg_r.mantissa),
    .rate     (rate)
  );

  assign out_load = !out_valid_r || out_ready;
  assign emit     = out_load && (stg_pcm_v_r || stg_sum_v_r);
  // The stage takes a byte when empty, or when the output loads and it holds one result.
  assign in_ready = !(stg_pcm_v_r || stg_sum_v_r) || (out_load && !(stg_pcm_v_r && stg_sum_v_r));
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_pcm_v_r <= 1'b0;
      stg_sum_v_r <= 1'b0;
    end else if (in_fire) begin
      stg_pcm_v_r <= res.pcm_v;
      stg_sum_v_r <= res.sum_v;
    end else if (emit) begin
      if (stg_pcm_v_r) begin
        stg_pcm_v_r <= 1'b0;
      end else begin
        stg_sum_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= stg_pcm_v_r || stg_sum_v_r;
    end
  end

  // The pass-through request goes out before the summary of the same byte.
  always_ff @(posedge clk) begin
    if (emit) begin
      if (stg_pcm_v_r) begin
        out_kind_r         <= aiff_hp_pkg::KIND_PCM;
        out_pcm_byte_r     <= stg_r.pcm_byte;
        out_channels_r     <= 16'd0;
        out_sample_bytes_r <= 2'd0;
        out_sample_rate_r  <= 32'd0;
        out_pcm_begin_r    <= 32'd0;
        out_pcm_end_r      <= 32'd0;
        out_status_r       <= aiff_hp_pkg::ST_OK;
        out_run_end_r      <= stg_r.pcm_run_end;
      end else begin
        out_kind_r         <= aiff_hp_pkg::KIND_SUM;
        out_pcm_byte_r     <= 8'd0;
        out_channels_r     <= stg_r.channels;
        out_sample_bytes_r <= stg_r.sample_bytes;
        out_sample_rate_r  <= rate;
        out_pcm_begin_r    <= stg_r.pcm_begin;
        out_pcm_end_r      <= stg_r.pcm_end;
        out_status_r       <= stg_r.status;
        out_run_end_r      <= 1'b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_pcm_byte     = out_pcm_byte_r;
  assign out_channels     = out_channels_r;
  assign out_sample_bytes = out_sample_bytes_r;
  assign out_sample_rate  = out_sample_rate_r;
  assign out_pcm_begin    = out_pcm_begin_r;
  assign out_pcm_end      = out_pcm_end_r;
  assign out_status       = out_status_r;
  assign out_run_end      = out_run_end_r;

  // A pass-through request that does not end its run is always followed by
  // the summary of the same byte.
  a_pcm_then_sum : assert property (@(posedge clk) disable iff (!rst_n)
    (stg_pcm_v_r && !stg_r.pcm_run_end) |-> stg_sum_v_r)
    else $error("pcm result without its end-of-file summary");

  a_fail_fields_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == aiff_hp_pkg::KIND_SUM && out_status != aiff_hp_pkg::ST_OK)
    |-> (out_channels == 16'd0 && out_sample_rate == 32'd0 && out_pcm_end == 32'd0))
    else $error("failed summary carries format fields");

  a_pcm_fields_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == aiff_hp_pkg::KIND_PCM)
    |-> (out_status == aiff_hp_pkg::ST_OK && out_pcm_begin == 32'd0 &&
         out_sample_bytes == 2'd0))
    else $error("pcm result carries summary fields");

  a_stage_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    (stg_pcm_v_r && stg_sum_v_r) |-> !in_ready)
    else $error("input taken while two results are pending");

endmodule
